### rtl/rtg_pkg.sv
// ----------------------------------------------------------------------------
// rtg_pkg : shared types and constants for the rgbe to gamma byte converter
// Channel width, item kind codes and the per-channel output path selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rtg_pkg;

	// width of one colour byte and of the table column index
	localparam int CHAN_W = 8;

	// number of colour channels handled side by side
	localparam int NUM_CHAN = 3;

	// item kind carried in tuser
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// where a channel's output byte comes from
	typedef enum logic [1:0] {
		PATH_TABLE = 2'd0,
		PATH_SAT   = 2'd1,
		PATH_ZERO  = 2'd2
	} path_t;

endpackage

`default_nettype wire

### rtl/rtg_ram.sv
// ----------------------------------------------------------------------------
// rtg_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module rtg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/rtg_chan_addr.sv
// ----------------------------------------------------------------------------
// rtg_chan_addr : per-channel exponent decode and table address
// Picks the output path from the unbiased exponent and forms row and column.
// ----------------------------------------------------------------------------
`default_nettype none

module rtg_chan_addr #(
	parameter int MAX_SHIFT = 15
) (
	input  wire logic        [rtg_pkg::CHAN_W-1:0]   mant,
	input  wire logic signed [9:0]                   exp_unb,
	output rtg_pkg::path_t                           path,
	output logic             [$clog2(MAX_SHIFT+1)-1:0] row,
	output logic             [rtg_pkg::CHAN_W-1:0]   col
);

	localparam int ROW_W = $clog2(MAX_SHIFT + 1);

	localparam logic signed [9:0] E_SAT     = 10'sd8;
	localparam logic signed [9:0] E_ROW_LOW = -$signed(10'(MAX_SHIFT));
	localparam logic signed [9:0] E_ZERO    = E_ROW_LOW - 10'sd8;

	logic [15:0] up_val;
	logic [2:0]  up_sh;
	logic [2:0]  dn_sh;
	logic [8:0]  dn_sum;

	// exponent range decode
	always_comb begin
		path   = rtg_pkg::PATH_TABLE;
		row    = '0;
		col    = mant;
		up_sh  = 3'(exp_unb[2:0] - 3'd1);
		up_val = {7'b0, mant, 1'b1} << up_sh;
		dn_sh  = 3'(E_ROW_LOW - 10'sd1 - exp_unb);
		dn_sum = {1'b0, mant >> dn_sh} + 9'd1;
		if (exp_unb > E_SAT) begin
			path = rtg_pkg::PATH_SAT;
		end else if (exp_unb > 10'sd0) begin
			// left shift with half lsb, saturate past one byte
			if (up_val[15:8] != 8'd0) begin
				path = rtg_pkg::PATH_SAT;
			end else begin
				col = up_val[7:0];
			end
		end else if (exp_unb >= E_ROW_LOW) begin
			// exponent selects the row directly
			row = ROW_W'(-exp_unb);
		end else if (exp_unb >= E_ZERO) begin
			// rounded right shift into the last row
			row = ROW_W'(MAX_SHIFT);
			col = dn_sum[8:1];
		end else begin
			path = rtg_pkg::PATH_ZERO;
		end
	end

endmodule

`default_nettype wire

### rtl/rgbe_to_gamma_bytes_unit.sv
// ----------------------------------------------------------------------------
// rgbe_to_gamma_bytes_unit : shared-exponent rgbe to gamma corrected rgb8
// Four-stage pipeline around a loadable gamma table held in three ram copies.
// ----------------------------------------------------------------------------
// The block takes one word per clock while m_tready is high or stage 4 is
// empty, and gives one pixel word per pixel word taken; a pixel word passes
// the stage 2, 3 and 4 registers to the master side. A word with tuser low
// loads one gamma table entry (row, column, byte) and gives no output; a word
// with tuser high converts one pixel. The stages are the input register, the
// exponent decode and table address, the registered table read and the output
// select; one global advance enable moves them all, so a stall holds every
// stage. The table is (MAX_SHIFT+1) x 256 bytes, kept as three identical ram
// copies so that all three channels read in the same cycle; it has no reset
// and no clearing pass, and every entry a pixel reads must be loaded first.
// A load whose row exceeds MAX_SHIFT is dropped. exp_out is always EXP_BIAS.
`default_nettype none

module rgbe_to_gamma_bytes_unit #(
	parameter int MAX_SHIFT = 15,
	parameter int EXP_BIAS  = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: red_mant, green_mant, blue_mant, shared_exp, table_row,
	//        table_col, table_value, zero pad
	input  wire logic [55:0] s_tdata,
	// tuser: func
	input  wire logic        s_tuser,
	// tlast: end_of_line
	input  wire logic        s_tlast,
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: red_out, green_out, blue_out, exp_out
	output logic [31:0]      m_tdata,
	// tlast: line_end_out
	output logic             m_tlast
);

	localparam int ROW_W  = $clog2(MAX_SHIFT + 1);
	localparam int ADDR_W = ROW_W + rtg_pkg::CHAN_W;
	localparam int DEPTH  = (MAX_SHIFT + 1) * 256;
	localparam int NC     = rtg_pkg::NUM_CHAN;
	localparam int CW     = rtg_pkg::CHAN_W;

	logic en;

	// stage 1: input register
	logic                valid_s1;
	logic                func_s1;
	logic                eol_s1;
	logic [CW-1:0]       mant_s1 [NC];
	logic signed [9:0]   exp_unb_s1;
	logic [3:0]          trow_s1;
	logic [CW-1:0]       tcol_s1;
	logic [CW-1:0]       tval_s1;

	// stage 2: table address
	logic                valid_s2;
	logic                pixel_s2;
	logic                eol_s2;
	logic                we_s2;
	logic [CW-1:0]       wdata_s2;
	logic [ADDR_W-1:0]   addr_s2 [NC];
	rtg_pkg::path_t      path_s2 [NC];

	// stage 3: table read
	logic                valid_s3;
	logic                eol_s3;
	rtg_pkg::path_t      path_s3 [NC];
	logic [CW-1:0]       rdata_s3 [NC];

	// stage 4: output register
	logic                valid_s4;
	logic                eol_s4;
	logic [CW-1:0]       chan_s4 [NC];

	// decode results
	rtg_pkg::path_t      dec_path [NC];
	logic [ROW_W-1:0]    dec_row [NC];
	logic [CW-1:0]       dec_col [NC];
	logic                row_ok;

	// global advance
	assign en       = !valid_s4 || m_tready;
	assign s_tready = en;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && pixel_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1 capture with exponent unbias
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1    <= s_tuser;
			eol_s1     <= s_tlast;
			mant_s1[0] <= s_tdata[7:0];
			mant_s1[1] <= s_tdata[15:8];
			mant_s1[2] <= s_tdata[23:16];
			exp_unb_s1 <= $signed({2'b00, s_tdata[31:24]}) - $signed(10'(EXP_BIAS));
			trow_s1    <= s_tdata[35:32];
			tcol_s1    <= s_tdata[43:36];
			tval_s1    <= s_tdata[51:44];
		end
	end

	// per-channel decode
	for (genvar c = 0; c < NC; c++) begin : g_dec
		rtg_chan_addr #(
			.MAX_SHIFT(MAX_SHIFT)
		) u_dec (
			.mant   (mant_s1[c]),
			.exp_unb(exp_unb_s1),
			.path   (dec_path[c]),
			.row    (dec_row[c]),
			.col    (dec_col[c])
		);
	end

	// load rows past the table are dropped
	assign row_ok = {1'b0, trow_s1} <= 5'(MAX_SHIFT);

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s2 <= 1'b0;
		end else if (en) begin
			we_s2 <= valid_s1 && (func_s1 == rtg_pkg::FUNC_LOAD) && row_ok;
		end
	end

	// stage 2 payload: a load drives the same address into every copy
	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s2 <= (func_s1 == rtg_pkg::FUNC_PIXEL);
			eol_s2   <= eol_s1;
			wdata_s2 <= tval_s1;
			for (int c = 0; c < NC; c++) begin
				path_s2[c] <= dec_path[c];
				if (func_s1 == rtg_pkg::FUNC_LOAD) begin
					addr_s2[c] <= {ROW_W'(trow_s1), tcol_s1};
				end else begin
					addr_s2[c] <= {dec_row[c], dec_col[c]};
				end
			end
		end
	end

	// table copies, one per channel
	for (genvar c = 0; c < NC; c++) begin : g_ram
		rtg_ram #(
			.WIDTH(CW),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (en && we_s2),
			.waddr(addr_s2[c]),
			.wdata(wdata_s2),
			.re   (en),
			.raddr(addr_s2[c]),
			.rdata(rdata_s3[c])
		);
	end

	// stage 3 payload alongside the read data
	always_ff @(posedge clk) begin
		if (en) begin
			eol_s3 <= eol_s2;
			for (int c = 0; c < NC; c++) begin
				path_s3[c] <= path_s2[c];
			end
		end
	end

	// stage 4 output select
	always_ff @(posedge clk) begin
		if (en) begin
			eol_s4 <= eol_s3;
			for (int c = 0; c < NC; c++) begin
				unique case (path_s3[c])
					rtg_pkg::PATH_TABLE: chan_s4[c] <= rdata_s3[c];
					rtg_pkg::PATH_SAT:   chan_s4[c] <= {CW{1'b1}};
					rtg_pkg::PATH_ZERO:  chan_s4[c] <= '0;
					default:             chan_s4[c] <= '0;
				endcase
			end
		end
	end

	// output word
	assign m_tvalid = valid_s4;
	assign m_tdata  = {8'(EXP_BIAS), chan_s4[2], chan_s4[1], chan_s4[0]};
	assign m_tlast  = eol_s4;

	// a free output side never blocks the input
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with output ready");

	// a new output word comes only from a pixel in the read stage
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s3 && en))
		else $error("output word without a pixel behind it");

	// saturating path gives a full byte
	a_sat_red: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s3 && path_s3[0] == rtg_pkg::PATH_SAT) |=> (m_tdata[7:0] == 8'hFF))
		else $error("saturated red not 255");

	// underflow path gives zero
	a_zero_blue: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s3 && path_s3[2] == rtg_pkg::PATH_ZERO) |=> (m_tdata[23:16] == 8'h00))
		else $error("underflowed blue not zero");

endmodule

`default_nettype wire
